[src/arm_gravity_torque_defines.svh]
// assertion macros used by the checker of the arm gravity torque block
`ifndef ARM_GRAVITY_TORQUE_DEFINES_SVH
`define ARM_GRAVITY_TORQUE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define AGT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define AGT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/agt_pkg.sv]
`timescale 1ns / 1ps

package agt_pkg;

	// binary angle resolution of the joint inputs, 10 to 16
	localparam int ANGLE_BITS = 16;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 16;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;

	localparam int COS_STAGES  = 7;
	localparam int PIPE_STAGES = 10;
	localparam int COS_W       = 32;
	localparam int HORNER_W    = 31;

	typedef enum logic [IDX_W-1:0] {
		REG_UPPER_ARM_LENGTH = 3'd0,
		REG_FOREARM_LENGTH   = 3'd1,
		REG_UPPER_ARM_MASS   = 3'd2,
		REG_ELBOW_MOTOR_MASS = 3'd3,
		REG_FOREARM_MASS     = 3'd4,
		REG_GRIPPER_MASS     = 3'd5,
		REG_PAYLOAD_MASS     = 3'd6,
		REG_GRAVITY_ACCEL    = 3'd7
	} reg_idx_t;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40168
	};

	// cosine polynomial in w = x^2, Q30
	localparam logic [HORNER_W-1:0] COS_COEF [5] = '{
		31'd1324675879, 31'd272375560, 31'd22401992, 31'd987048, 31'd27061
	};

	localparam logic [HORNER_W-1:0] Q30_ONE = 31'h4000_0000;

	// static torque coefficients at scale 2^19
	typedef struct packed {
		logic [31:0] ta;
		logic [31:0] tb;
	} coef_t;

endpackage

[src/agt_cfg.sv]
`timescale 1ns / 1ps

module agt_cfg import agt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output coef_t             coef
);

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic [19:0]      mass_a_q;
	logic [18:0]      mass_b_q;
	logic [35:0]      len_mass_a_q;
	logic [34:0]      len_mass_b_q;
	logic [51:0]      full_a;
	logic [50:0]      full_b;
	logic [IDX_W-1:0] idx;

	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata[REG_W-1:0];
		end
	end

	assign prdata = {16'd0, regs_q[idx]};

	// doubled mass sums, then length products, then gravity
	always_ff @(posedge clk) begin
		mass_a_q <= 20'(regs_q[REG_UPPER_ARM_MASS])
			+ 20'({regs_q[REG_ELBOW_MOTOR_MASS], 1'b0})
			+ 20'({regs_q[REG_FOREARM_MASS], 1'b0})
			+ 20'({regs_q[REG_GRIPPER_MASS], 1'b0})
			+ 20'({regs_q[REG_PAYLOAD_MASS], 1'b0});
		mass_b_q <= 19'(regs_q[REG_FOREARM_MASS])
			+ 19'({regs_q[REG_GRIPPER_MASS], 1'b0})
			+ 19'({regs_q[REG_PAYLOAD_MASS], 1'b0});
		len_mass_a_q <= 36'(regs_q[REG_UPPER_ARM_LENGTH]) * 36'(mass_a_q);
		len_mass_b_q <= 35'(regs_q[REG_FOREARM_LENGTH]) * 35'(mass_b_q);
		coef.ta <= full_a[51:20];
		coef.tb <= {1'b0, full_b[50:20]};
	end

	assign full_a = 52'(len_mass_a_q) * 52'(regs_q[REG_GRAVITY_ACCEL]);
	assign full_b = 51'(len_mass_b_q) * 51'(regs_q[REG_GRAVITY_ACCEL]);

endmodule

[src/agt_cos.sv]
`timescale 1ns / 1ps

module agt_cos import agt_pkg::*; (
	input  logic                    clk,
	input  logic [COS_STAGES-1:0]   en,
	input  logic [15:0]             phase,
	output logic signed [COS_W-1:0] cos_q30
);

	logic [14:0]         r_s1;
	logic                neg_s1;
	logic [HORNER_W-1:0] w_s2, w_s3, w_s4, w_s5, w_s6;
	logic                neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [HORNER_W-1:0] p3_s3, p2_s4, p1_s5, p0_s6;
	logic [14:0]         r_fold;
	logic [61:0]         last_prod;
	logic signed [31:0]  last_val;
	logic [HORNER_W-1:0] mag;

	function automatic logic [HORNER_W-1:0] horner_step(
		input logic [HORNER_W-1:0] c,
		input logic [HORNER_W-1:0] p,
		input logic [HORNER_W-1:0] w
	);
		logic [61:0] prod;
		prod = 62'(p) * 62'(w);
		return c - prod[60:30];
	endfunction

	// odd quadrants mirror about the quarter turn
	assign r_fold = phase[14] ? (15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s1   <= r_fold;
			neg_s1 <= phase[15] ^ phase[14];
		end
		if (en[1]) begin
			// w = r^2 * 4, the square of r in q30
			w_s2   <= {29'(30'(r_s1) * 30'(r_s1)), 2'b00};
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			p3_s3  <= horner_step(COS_COEF[3], COS_COEF[4], w_s2);
			w_s3   <= w_s2;
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			p2_s4  <= horner_step(COS_COEF[2], p3_s3, w_s3);
			w_s4   <= w_s3;
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			p1_s5  <= horner_step(COS_COEF[1], p2_s4, w_s4);
			w_s5   <= w_s4;
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			p0_s6  <= horner_step(COS_COEF[0], p1_s5, w_s5);
			w_s6   <= w_s5;
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			cos_q30 <= neg_s6 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	// last term, clamped to [0, one]
	assign last_prod = 62'(p0_s6) * 62'(w_s6);
	assign last_val  = $signed({1'b0, Q30_ONE}) - $signed({1'b0, last_prod[60:30]});
	assign mag = last_val[31] ? '0 :
		(last_val > $signed({1'b0, Q30_ONE})) ? Q30_ONE : last_val[HORNER_W-1:0];

endmodule

[src/arm_gravity_torque.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                        payload
// s_*       in         s_tvalid / s_tready              s_tdata: shoulder_angle, elbow_angle
// m_*       out        m_tvalid / m_tready              m_tdata: shoulder_torque, elbow_torque
// apb       in/out     psel, penable, pwrite, pready=1  paddr, pwdata, prdata
//
// ten register stages from input to output; one item per cycle sustained
// while m_tready is high. the depth is set by the horner chain of the cosine
// (one multiply per stage) followed by the torque multiply, sum and rounding
// stages. reset clears the valid bits and sets the register defaults, but not
// the data registers; no clearing pass is needed. each stage moves on when it
// is empty or the next one moves, so bubbles close up under output back-pressure
// and an input item still fills a bubble while a result waits in the output register.

module arm_gravity_torque import agt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input item
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,  // [15:0] shoulder_angle, [31:16] elbow_angle
	// result item
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,  // [31:0] shoulder_torque, [63:32] elbow_torque
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [PIPE_STAGES:1]    stage_valid_q;
	logic [PIPE_STAGES:1]    adv;
	coef_t                   coef;
	logic [15:0]             ph_shoulder, ph_elbow, ph_sum;
	logic signed [COS_W-1:0] cos_sh, cos_sum;
	logic signed [63:0]      prod_a, prod_b;
	logic signed [62:0]      prod_a_s8, prod_b_s8;
	logic signed [63:0]      shoulder_s9, elbow_s9;
	logic signed [31:0]      shoulder_s10, elbow_s10;

	// binary angle to a 16-bit phase over one turn
	function automatic logic [15:0] phase_of(input logic [15:0] ang);
		logic [31:0] wide;
		wide = {{16{ang[15]}}, ang} << (32 - ANGLE_BITS);
		return wide[31:16];
	endfunction

	// scale 2^49 to q16.16, half away from zero, saturated
	function automatic logic signed [31:0] to_q16(input logic signed [63:0] x);
		logic signed [65:0] rnd;
		logic signed [32:0] q;
		rnd = 66'(x) + 66'sh1_0000_0000 - 66'(x[63]);
		q   = rnd[65:33];
		if (q[32] != q[31]) begin
			return q[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return q[31:0];
	endfunction

	assign pready = 1'b1;

	agt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef    (coef)
	);

	// stage advance, from the output backwards
	always_comb begin
		adv[PIPE_STAGES] = !stage_valid_q[PIPE_STAGES] || m_tready;
		for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
			adv[k] = !stage_valid_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_valid_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= PIPE_STAGES; k++) begin
				if (adv[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	// the outer link angle wraps over one turn
	assign ph_shoulder = phase_of(s_tdata[15:0]);
	assign ph_elbow    = phase_of(s_tdata[31:16]);
	assign ph_sum      = ph_shoulder + ph_elbow;

	// stages one to seven: fold, square, horner chain
	agt_cos u_cos_shoulder (
		.clk     (clk),
		.en      (adv[COS_STAGES:1]),
		.phase   (ph_shoulder),
		.cos_q30 (cos_sh)
	);

	agt_cos u_cos_sum (
		.clk     (clk),
		.en      (adv[COS_STAGES:1]),
		.phase   (ph_sum),
		.cos_q30 (cos_sum)
	);

	// after a register write the coefficients settle through the mass sum, length
	// product and coefficient registers, well before a following item reaches stage eight
	assign prod_a = $signed({1'b0, coef.ta}) * cos_sh;
	assign prod_b = $signed({1'b0, coef.tb}) * cos_sum;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			prod_a_s8 <= prod_a[62:0];
			prod_b_s8 <= prod_b[62:0];
		end
		if (adv[9]) begin
			shoulder_s9 <= 64'(prod_a_s8) + 64'(prod_b_s8);
			elbow_s9    <= 64'(prod_b_s8);
		end
		if (adv[10]) begin
			shoulder_s10 <= to_q16(shoulder_s9);
			elbow_s10    <= to_q16(elbow_s9);
		end
	end

	assign m_tvalid = stage_valid_q[PIPE_STAGES];
	assign m_tdata  = {elbow_s10, shoulder_s10};

endmodule

[src/agt_checker.sv]
`timescale 1ns / 1ps
`include "arm_gravity_torque_defines.svh"

module agt_checker import agt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [63:0]       m_tdata,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);

	`AGT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
	`AGT_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input stalled with output register empty")
	`AGT_ASSERT_NOW(a_drain_ready, m_tready, s_tready, "input stalled while output drains")
	`AGT_ASSERT_NOW(a_readback, (psel && penable && pwrite && pready) ##1 (psel && !pwrite && (paddr[ADDR_W-1:2] == $past(paddr[ADDR_W-1:2]))), prdata[15:0] == $past(pwdata[15:0]), "register readback differs from write")

endmodule

bind arm_gravity_torque agt_checker u_agt_checker (.*);

[tb/arm_torque_checker.sv]
`timescale 1ns / 1ps

module arm_torque_checker import agt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,  // [15:0] shoulder_angle, [31:16] elbow_angle
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [63:0]       m_tdata,  // [31:0] shoulder_torque, [63:32] elbow_torque
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                fail_count,
	output int                torques_due,
	output int                torques_checked,
	output int                reads_checked
);

	localparam longint Q30_UNIT = 64'sd1073741824;
	localparam longint COS_TERMS [5] = '{
		64'sd1324675879, 64'sd272375560, 64'sd22401992, 64'sd987048, 64'sd27061
	};
	localparam logic [15:0] ARM_REG_RESET [8] = '{
		16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40168
	};

	typedef struct {
		logic [31:0] shoulder;
		logic [31:0] elbow;
	} torque_pair_t;

	logic [15:0]  arm_reg [8];
	torque_pair_t torque_due_q [$];
	torque_pair_t due;
	int           mismatches = 0;
	int           due_count = 0;
	int           result_count = 0;
	int           read_count = 0;

	assign fail_count      = mismatches;
	assign torques_due     = due_count;
	assign torques_checked = result_count;
	assign reads_checked   = read_count;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatches < 100)
			$display("checker: %s: expected %h, got %h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// signed binary angle to a 16-bit phase of one turn
	function automatic logic [15:0] angle_phase(input logic [15:0] field);
		logic [63:0] a;
		a = {{48{field[15]}}, field};
		a &= (64'd1 << ANGLE_BITS) - 64'd1;
		return 16'(((a << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF) >> 16);
	endfunction

	// first-quadrant cosine, r in [0, 2^14], Q30 result clamped to [0, 1]
	function automatic longint quadrant_cosine(input logic [14:0] r);
		longint z;
		longint w;
		longint p;
		int     k;
		z = longint'(r) << 16;
		w = (z * z) >>> 30;
		p = COS_TERMS[4];
		for (k = 3; k >= 0; k--)
			p = COS_TERMS[k] - ((p * w) >>> 30);
		p = Q30_UNIT - ((p * w) >>> 30);
		if (p < 0)
			p = 0;
		if (p > Q30_UNIT)
			p = Q30_UNIT;
		return p;
	endfunction

	function automatic longint joint_cosine(input logic [15:0] ph);
		logic [14:0] r;
		r = {1'b0, ph[13:0]};
		case (ph[15:14])
			2'd0: return quadrant_cosine(r);
			2'd1: return -quadrant_cosine(15'd16384 - r);
			2'd2: return -quadrant_cosine(r);
			default: return quadrant_cosine(15'd16384 - r);
		endcase
	endfunction

	// scale 2^49 to q16.16, half away from zero, clamped to 32 bits
	function automatic logic [31:0] round_to_q16(input longint x);
		longint          r;
		longint unsigned m;
		if (x >= 0) begin
			m = longint'(x);
			r = longint'((m + (64'd1 << 32)) >> 33);
		end else begin
			m = longint'(-x);
			r = -longint'((m + (64'd1 << 32)) >> 33);
		end
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic torque_pair_t gravity_torques(input logic [15:0] shoulder_ang,
			input logic [15:0] elbow_ang);
		longint unsigned l1, l2, mu, me, mf, mg, mp, g;
		longint unsigned tip2, ma2, mb2;
		longint          ta, tb, c2, c23, elbow_t, shoulder_t;
		logic [15:0]     ps, pe, psum;
		torque_pair_t    res;
		l1 = arm_reg[REG_UPPER_ARM_LENGTH];
		l2 = arm_reg[REG_FOREARM_LENGTH];
		mu = arm_reg[REG_UPPER_ARM_MASS];
		me = arm_reg[REG_ELBOW_MOTOR_MASS];
		mf = arm_reg[REG_FOREARM_MASS];
		mg = arm_reg[REG_GRIPPER_MASS];
		mp = arm_reg[REG_PAYLOAD_MASS];
		g  = arm_reg[REG_GRAVITY_ACCEL];
		// doubled mass sums at 2^13, static coefficients at 2^19
		tip2 = 2 * mg + 2 * mp;
		ma2  = mu + 2 * me + 2 * mf + tip2;
		mb2  = mf + tip2;
		ta   = longint'((l1 * ma2 * g) >> 20);
		tb   = longint'((l2 * mb2 * g) >> 20);
		ps   = angle_phase(shoulder_ang);
		pe   = angle_phase(elbow_ang);
		psum = ps + pe;
		c2   = joint_cosine(ps);
		c23  = joint_cosine(psum);
		elbow_t    = tb * c23;
		shoulder_t = ta * c2 + elbow_t;
		res.shoulder = round_to_q16(shoulder_t);
		res.elbow    = round_to_q16(elbow_t);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_due_q.delete();
			arm_reg = ARM_REG_RESET;
			due_count = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					arm_reg[paddr[ADDR_W-1:2]] = pwdata[15:0];
				end else begin
					read_count++;
					if (prdata[15:0] !== arm_reg[paddr[ADDR_W-1:2]])
						report_mismatch("register read", {16'd0, arm_reg[paddr[ADDR_W-1:2]]},
							{16'd0, prdata[15:0]});
				end
			end
			if (s_tvalid && s_tready)
				torque_due_q.push_back(gravity_torques(s_tdata[15:0], s_tdata[31:16]));
			if (m_tvalid && m_tready) begin
				result_count++;
				if (torque_due_q.size() == 0) begin
					report_mismatch("result with nothing due", 32'd0, m_tdata[31:0]);
				end else begin
					due = torque_due_q.pop_front();
					if (m_tdata[31:0] !== due.shoulder)
						report_mismatch("shoulder_torque", due.shoulder, m_tdata[31:0]);
					if (m_tdata[63:32] !== due.elbow)
						report_mismatch("elbow_torque", due.elbow, m_tdata[63:32]);
				end
			end
			due_count = torque_due_q.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import agt_pkg::*;

	// generous ceiling for a clean run
	localparam int CYCLE_LIMIT  = 200000;
	// settling time after the last result
	localparam int DRAIN_CYCLES = 2 * PIPE_STAGES;

	// one full set of arm registers
	typedef struct {
		logic [15:0] upper_arm_length;
		logic [15:0] forearm_length;
		logic [15:0] upper_arm_mass;
		logic [15:0] elbow_motor_mass;
		logic [15:0] forearm_mass;
		logic [15:0] gripper_mass;
		logic [15:0] payload_mass;
		logic [15:0] gravity_accel;
	} arm_setting_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;    // [15:0] shoulder_angle, [31:16] elbow_angle
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [63:0]       m_tdata;         // [31:0] shoulder_torque, [63:32] elbow_torque
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int torques_due;
	int torques_checked;
	int reads_checked;

	// idle chances in percent, changed by the main sequence per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int settings_loaded = 0;
	int cycle_count = 0;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	arm_gravity_torque dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// watches both streams and the register port, predicts and compares
	arm_torque_checker torque_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.fail_count      (fail_count),
		.torques_due     (torques_due),
		.torques_checked (torques_checked),
		.reads_checked   (reads_checked)
	);

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results still due",
				cycle_count, torques_due);
			$display("tb: done, errors");
			$finish;
		end
	end

	// result side back-pressure, one decision per falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one register access: setup cycle, access cycle, then a quiet cycle
	// so that back-to-back calls never drive psel twice in one step
	task automatic reg_access(input logic is_write, input reg_idx_t idx,
			input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		// junk in the upper half, the block keeps only 16 bits
		pwdata  <= {16'($urandom()), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// read every register back; the checker compares against its own copy
	task automatic read_all_regs();
		reg_access(1'b0, REG_UPPER_ARM_LENGTH, 16'd0);
		reg_access(1'b0, REG_FOREARM_LENGTH, 16'd0);
		reg_access(1'b0, REG_UPPER_ARM_MASS, 16'd0);
		reg_access(1'b0, REG_ELBOW_MOTOR_MASS, 16'd0);
		reg_access(1'b0, REG_FOREARM_MASS, 16'd0);
		reg_access(1'b0, REG_GRIPPER_MASS, 16'd0);
		reg_access(1'b0, REG_PAYLOAD_MASS, 16'd0);
		reg_access(1'b0, REG_GRAVITY_ACCEL, 16'd0);
	endtask

	// only called with the pipeline empty
	task automatic load_setting(input arm_setting_t s);
		reg_access(1'b1, REG_UPPER_ARM_LENGTH, s.upper_arm_length);
		reg_access(1'b1, REG_FOREARM_LENGTH, s.forearm_length);
		reg_access(1'b1, REG_UPPER_ARM_MASS, s.upper_arm_mass);
		reg_access(1'b1, REG_ELBOW_MOTOR_MASS, s.elbow_motor_mass);
		reg_access(1'b1, REG_FOREARM_MASS, s.forearm_mass);
		reg_access(1'b1, REG_GRIPPER_MASS, s.gripper_mass);
		reg_access(1'b1, REG_PAYLOAD_MASS, s.payload_mass);
		reg_access(1'b1, REG_GRAVITY_ACCEL, s.gravity_accel);
		read_all_regs();
		settings_loaded++;
	endtask

	function automatic arm_setting_t uniform_setting(input logic [15:0] v);
		arm_setting_t s;
		s = '{v, v, v, v, v, v, v, v};
		return s;
	endfunction

	function automatic arm_setting_t random_setting();
		arm_setting_t s;
		s.upper_arm_length = 16'($urandom());
		s.forearm_length   = 16'($urandom());
		s.upper_arm_mass   = 16'($urandom());
		s.elbow_motor_mass = 16'($urandom());
		s.forearm_mass     = 16'($urandom());
		s.gripper_mass     = 16'($urandom());
		s.payload_mass     = 16'($urandom());
		s.gravity_accel    = 16'($urandom());
		return s;
	endfunction

	// quarter-turn boundary give or take three
	function automatic logic [15:0] near_quadrant_edge();
		logic [15:0] a;
		a = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(6)) - 16'd3;
		return a;
	endfunction

	function automatic logic [15:0] pick_angle();
		logic [15:0] a;
		case ($urandom_range(3))
			0, 1: a = 16'($urandom());
			2: a = near_quadrant_edge();
			default: begin
				case ($urandom_range(3))
					0: a = 16'h8000;
					1: a = 16'h7fff;
					2: a = 16'h0000;
					default: a = 16'hffff;
				endcase
			end
		endcase
		return a;
	endfunction

	// offer one item after a random gap; returns at the falling edge after
	// it was taken, leaving tvalid high for a possible next item
	task automatic send_item(input logic [15:0] shoulder_ang, input logic [15:0] elbow_ang);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {elbow_ang, shoulder_ang};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// always waits for a falling edge first, then for the queue to empty
	task automatic await_all_torques();
		@(negedge clk);
		while (torques_due != 0)
			@(negedge clk);
	endtask

	// random angle pairs; a quarter of them aim the joint sum at a quadrant
	// edge, and pause_at >= 0 holds the sender until everything is back
	task automatic send_random_items(input int count, input int pause_at);
		logic [15:0] sa;
		logic [15:0] ea;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				await_all_torques();
			end
			sa = pick_angle();
			if ($urandom_range(3) == 0)
				ea = near_quadrant_edge() - sa;
			else
				ea = pick_angle();
			send_item(sa, ea);
		end
		s_tvalid <= 1'b0;
		await_all_torques();
	endtask

	initial begin
		arm_setting_t realistic;
		arm_setting_t heavy;
		arm_setting_t short_links;

		// reset asserted, then released on a falling edge
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values of the registers
		read_all_regs();

		// phase one: sender idles a little, receiver a lot
		send_idle_pct = 26;
		recv_idle_pct = 76;

		// everything at full scale, the largest torques reachable
		load_setting(uniform_setting(16'hffff));

		// directed angles: zero, quadrant edges, extremes, sum wrap
		send_item(16'h0000, 16'h0000);
		send_item(16'h4000, 16'h0000);
		send_item(16'h8000, 16'h0000);
		send_item(16'hc000, 16'h0000);
		send_item(16'h7fff, 16'h0000);
		send_item(16'hffff, 16'h0001);
		send_item(16'h7fff, 16'h7fff);
		send_item(16'h8000, 16'h8000);
		send_item(16'h4000, 16'h4000);
		send_item(16'h2000, 16'he000);
		send_item(16'h0001, 16'hffff);
		send_item(16'h3fff, 16'h0001);
		send_item(16'h5555, 16'haaaa);
		send_item(16'haaaa, 16'h5555);
		send_item(16'h1234, 16'hedcb);
		send_item(16'hc000, 16'h4000);
		s_tvalid <= 1'b0;
		await_all_torques();
		send_random_items(90, -1);

		// a plausible small arm: 0.4 m and 0.3 m links, a few kilograms
		realistic = '{16'd6554, 16'd4915, 16'd6144, 16'd3277,
			16'd4096, 16'd2048, 16'd8192, 16'd40168};
		load_setting(realistic);
		send_random_items(130, -1);

		// phase two: roles swapped
		send_idle_pct = 76;
		recv_idle_pct = 26;

		// all zero, torques must be zero everywhere
		load_setting(uniform_setting(16'h0000));
		send_random_items(60, -1);

		// random registers, sender holds off halfway until all is back
		load_setting(random_setting());
		send_random_items(140, 70);

		// phase three: no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;

		heavy = random_setting();
		heavy.gravity_accel = 16'hffff;
		heavy.payload_mass  = 16'hffff;
		load_setting(heavy);
		send_random_items(140, -1);

		// tiny links against random masses, small torques near rounding
		short_links = random_setting();
		short_links.upper_arm_length = 16'($urandom_range(1, 15));
		short_links.forearm_length   = 16'($urandom_range(1, 15));
		load_setting(short_links);
		send_random_items(130, -1);

		// let the pipeline settle, then catch any stray result
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("tb: %0d angle pairs under %0d register settings, %0d torque pairs checked",
			items_sent, settings_loaded, torques_checked);
		$display("tb: %0d register reads checked, idle mixes 26/76, 76/26 and none",
			reads_checked);
		if (fail_count == 0 && torques_due == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
